// ----- src/xorshift_ranged_random_macros.svh -----
// Assertion macros for the xorshift ranged random block.
// Used by modules that check their control logic; no other dependencies.
`ifndef XORSHIFT_RANGED_RANDOM_MACROS_SVH
`define XORSHIFT_RANGED_RANDOM_MACROS_SVH
`ifndef NO_ASSERTIONS
`define XRR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define XRR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define XRR_ASSERT(lbl, prop, msg)
`define XRR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- src/xrr_pkg.sv -----
// Shared types and constants for the xorshift ranged random block.
// No dependencies; imported by the controller, datapath and top level.
package xrr_pkg;

   localparam int WORD_W = 32;
   localparam int CNT_W  = $clog2(WORD_W);

   localparam logic [WORD_W-1:0] SEED_RESET = 32'd1;
   localparam logic [WORD_W-1:0] OUT_MULT   = 32'd314159265;
   localparam logic [CNT_W-1:0]  DIV_LAST   = CNT_W'(WORD_W - 1);

   localparam int SHIFT_A = 13;
   localparam int SHIFT_B = 17;
   localparam int SHIFT_C = 5;

   localparam logic ACT_RANGE  = 1'b0;
   localparam logic ACT_CHANCE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_PROD,
      ST_DIV,
      ST_FIN
   } fsm_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic prod;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic act;
      logic full;
   } sts_type;

   function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] t;
      t = w ^ (w << SHIFT_A);
      t = t ^ (t >> SHIFT_B);
      t = t ^ (t << SHIFT_C);
      return t;
   endfunction

endpackage

// ----- src/xorshift_ranged_random.sv -----
// Top level of the xorshift ranged random block.
// Depends on xrr_pkg, xrr_ctrl and xrr_datapath.
//
// Each req beat advances a 32-bit xorshift word (13, 17, 5) and forms the raw
// output as word * 314159265 mod 2^32. req_tuser selects the action: 0 returns
// raw mod (span+1) plus the smaller bound, 1 runs the chance test a over b.
// req_tdata carries bound_a in [31:0] and bound_b in [63:32]. rsp_tdata is the
// value, rsp_tuser the hit flag. csr_wdata loads the seed into the word; reset
// loads seed 1. Write the seed only while no beat is in flight.
// One beat is in work at a time. A range beat passes from accept to rsp_tvalid
// through the multiply state, the radix-2 remainder unit and the finish state;
// a full 2^32 span skips the divider. Chance beats pass through multiply,
// product and compare. The next req beat is taken the cycle after the result is
// registered, so no new beat is taken until the last one is through.
// A stalled rsp holds in its output register; the block accepts one more beat
// meanwhile and waits in its finish cycle until the register frees.
module xorshift_ranged_random
   import xrr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2*WORD_W-1:0] req_tdata,   // bound_a, bound_b
   input  logic                req_tuser,   // action
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [WORD_W-1:0]   rsp_tdata,   // value
   output logic                rsp_tuser,   // hit
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [WORD_W-1:0]   csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   xrr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_ready  (csr_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   xrr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .csr_we     (csr_valid & csr_ready),
      .csr_wdata  (csr_wdata),
      .in_action  (req_tuser),
      .in_bound_a (req_tdata[WORD_W-1:0]),
      .in_bound_b (req_tdata[2*WORD_W-1:WORD_W]),
      .out_value  (rsp_tdata),
      .out_hit    (rsp_tuser)
   );

endmodule

// ----- src/xrr_ctrl.sv -----
// Controller state machine for the xorshift ranged random block.
// Depends on xrr_pkg and xorshift_ranged_random_macros.svh.
`include "xorshift_ranged_random_macros.svh"

module xrr_ctrl
   import xrr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output logic    csr_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   fsm_type           state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      csr_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            csr_ready  = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            cnt_in  = '0;
            if (sts.act == ACT_CHANCE) begin
               state_in = ST_PROD;
            end else if (sts.full) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_FIN;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   `XRR_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
   `XRR_ASSERT(a_load_to_mul, cmd.load |=> state_ff == ST_MUL, "load not followed by multiply")
   `XRR_ASSERT(a_div_range_only, state_ff == ST_DIV |-> sts.act == ACT_RANGE,
      "divider running for a chance test")
   `XRR_ASSERT(a_rsp_from_fin, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FIN,
      "response raised outside finish")
   `XRR_ASSERT(a_no_overwrite, cmd.out_load |-> !rsp_valid_ff || rsp_tready,
      "pending response overwritten")

endmodule

// ----- src/xrr_datapath.sv -----
// Datapath of the xorshift ranged random block: generator word, output
// multiplier, chance-test product and radix-2 remainder unit. Depends on xrr_pkg.
module xrr_datapath
   import xrr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic              csr_we,
   input  logic [WORD_W-1:0] csr_wdata,
   input  logic              in_action,
   input  logic [WORD_W-1:0] in_bound_a,
   input  logic [WORD_W-1:0] in_bound_b,
   output logic [WORD_W-1:0] out_value,
   output logic              out_hit
);

   logic [WORD_W-1:0]   word_ff;
   logic [WORD_W-1:0]   a_ff, b_ff;
   logic                act_ff;
   logic [WORD_W-1:0]   raw_ff, quo_ff, rem_ff, lo_ff, div_ff;
   logic [2*WORD_W-1:0] prod_ff;
   logic [WORD_W-1:0]   value_ff;
   logic                hit_ff;

   logic [2*WORD_W-1:0] mult_full;
   logic [WORD_W-1:0]   lo, hi;
   logic                full;
   logic [WORD_W:0]     rem_sh, rem_sub;
   logic [2*WORD_W-1:0] rhs;
   logic                hit_in;
   logic [WORD_W-1:0]   value_in;

   assign mult_full = word_ff * OUT_MULT;
   assign lo        = (a_ff < b_ff) ? a_ff : b_ff;
   assign hi        = (a_ff < b_ff) ? b_ff : a_ff;
   assign full      = (lo == '0) && (hi == '1);
   assign rem_sh    = {rem_ff, quo_ff[WORD_W-1]};
   assign rem_sub   = rem_sh - {1'b0, div_ff};
   assign rhs       = {a_ff, {WORD_W{1'b0}}} - {{WORD_W{1'b0}}, a_ff};
   assign hit_in    = (act_ff == ACT_CHANCE) && (prod_ff < rhs);

   always_comb begin
      if (act_ff == ACT_CHANCE || full) begin
         value_in = raw_ff;
      end else begin
         value_in = rem_ff + lo_ff;
      end
   end

   // a seed write in the same cycle as a req beat takes effect first
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= SEED_RESET;
      end else if (csr_we) begin
         word_ff <= cmd.load ? xorshift(csr_wdata) : csr_wdata;
      end else if (cmd.load) begin
         word_ff <= xorshift(word_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff   <= in_bound_a;
         b_ff   <= in_bound_b;
         act_ff <= in_action;
      end
      if (cmd.mul) begin
         raw_ff <= mult_full[WORD_W-1:0];
         quo_ff <= mult_full[WORD_W-1:0];
         rem_ff <= '0;
         lo_ff  <= lo;
         div_ff <= hi - lo + 1'b1;
      end
      if (cmd.prod) begin
         prod_ff <= raw_ff * b_ff;
      end
      if (cmd.div_step) begin
         quo_ff <= {quo_ff[WORD_W-2:0], 1'b0};
         rem_ff <= rem_sub[WORD_W] ? rem_sh[WORD_W-1:0] : rem_sub[WORD_W-1:0];
      end
      if (cmd.out_load) begin
         value_ff <= value_in;
         hit_ff   <= hit_in;
      end
   end

   assign sts.act   = act_ff;
   assign sts.full  = full;
   assign out_value = value_ff;
   assign out_hit   = hit_ff;

endmodule

// ----- tb/xorshift_ranged_random_tb.sv -----
// Testbench for xorshift_ranged_random: directed and random range and chance beats
// over several seeds, each response beat checked in order against a local predictor.
// Depends on xrr_pkg and the xorshift_ranged_random RTL.
module xorshift_ranged_random_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import xrr_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              hit;
   } draw_type;

   class draw_predictor_type;
      logic [31:0] word;
      draw_type    expected_draws[$];
      int          errors;

      function new();
         word   = 32'd1;
         errors = 0;
      endfunction

      function void load_seed(logic [31:0] seed);
         word = seed;
      endfunction

      function int pending();
         return expected_draws.size();
      endfunction

      function void note_request(logic action, logic [31:0] a, logic [31:0] b);
         logic [31:0] raw;
         logic [31:0] lo;
         logic [31:0] hi;
         logic [31:0] span;
         logic [63:0] modulus;
         draw_type    d;
         word = word ^ (word << 13);
         word = word ^ (word >> 17);
         word = word ^ (word << 5);
         raw = word * 32'd314159265;
         d.value = raw;
         d.hit = 1'b0;
         if (action == ACT_RANGE) begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            span = hi - lo;
            // full span: raw passes through untouched
            if (span != 32'hFFFF_FFFF) begin
               modulus = {32'd0, span} + 64'd1;
               d.value = 32'({32'd0, raw} % modulus) + lo;
            end
         end else begin
            d.hit = ({32'd0, raw} * {32'd0, b}) < ({32'd0, a} * 64'h0000_0000_FFFF_FFFF);
         end
         expected_draws.push_back(d);
      endfunction

      function void check_draw(logic [31:0] value, logic hit);
         draw_type d;
         if (expected_draws.size() == 0) begin
            $error("unexpected response beat: value %h hit %b", value, hit);
            errors++;
            return;
         end
         d = expected_draws.pop_front();
         if (value !== d.value) begin
            $error("value: expected %h, actual %h", d.value, value);
            errors++;
         end
         if (hit !== d.hit) begin
            $error("hit: expected %b, actual %b", d.hit, hit);
            errors++;
         end
      endfunction
   endclass

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [2*WORD_W-1:0] req_tdata  = '0;    // bound_a, bound_b
   logic                req_tuser  = 1'b0;  // action
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [WORD_W-1:0]   rsp_tdata;          // value
   logic                rsp_tuser;          // hit
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [WORD_W-1:0]   csr_wdata  = '0;

   logic               calm   = 1'b0;
   int                 cycles = 0;
   draw_predictor_type draws  = new();

   xorshift_ranged_random dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 10);
   end

   // outputs are stable from negedge to the accepting edge
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) draws.check_draw(rsp_tdata, rsp_tuser);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] pick_bound();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 15);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
         2: return 32'd1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_draw(input logic action, input logic [31:0] a, input logic [31:0] b);
      logic taken;
      if (!calm && $urandom_range(0, 99) < 10) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tuser  <= action;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      draws.note_request(action, a, b);
   endtask

   task automatic send_random(input int count);
      logic        action;
      logic [31:0] a;
      logic [31:0] b;
      repeat (count) begin
         action = 1'($urandom_range(0, 1));
         a = pick_bound();
         b = pick_bound();
         // bias chance beats toward a <= b
         if (action == ACT_CHANCE && $urandom_range(0, 1) == 1 && a > b) {a, b} = {b, a};
         send_draw(action, a, b);
      end
   endtask

   task automatic write_seed(input logic [31:0] seed);
      logic taken;
      req_tvalid <= 1'b0;
      while (draws.pending() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= seed;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      draws.load_seed(seed);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset seed; bound order, full span, zero span, zero denominator
      send_draw(ACT_RANGE,  32'h0000_0000, 32'hFFFF_FFFF);
      send_draw(ACT_RANGE,  32'hFFFF_FFFF, 32'h0000_0000);
      send_draw(ACT_RANGE,  32'h0000_0000, 32'h0000_0000);
      send_draw(ACT_RANGE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_draw(ACT_RANGE,  32'd5,         32'd10);
      send_draw(ACT_RANGE,  32'd10,        32'd5);
      send_draw(ACT_RANGE,  32'd0,         32'd1);
      send_draw(ACT_RANGE,  32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_draw(ACT_RANGE,  32'd1,         32'hFFFF_FFFF);
      send_draw(ACT_RANGE,  32'hFFFF_FFFE, 32'd0);
      send_draw(ACT_RANGE,  32'h8000_0000, 32'h7FFF_FFFF);
      send_draw(ACT_CHANCE, 32'd0,         32'd0);
      send_draw(ACT_CHANCE, 32'd1,         32'd0);
      send_draw(ACT_CHANCE, 32'hFFFF_FFFF, 32'd0);
      send_draw(ACT_CHANCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_draw(ACT_CHANCE, 32'd0,         32'hFFFF_FFFF);
      send_draw(ACT_CHANCE, 32'd1,         32'd2);
      send_draw(ACT_CHANCE, 32'd1,         32'd1);
      send_draw(ACT_CHANCE, 32'h8000_0000, 32'hFFFF_FFFF);
      send_draw(ACT_CHANCE, 32'hFFFF_FFFF, 32'd1);

      // zero seed locks the word at zero
      write_seed(32'h0000_0000);
      send_random(12);

      write_seed(32'hFFFF_FFFF);
      send_random(300);

      write_seed($urandom);
      calm <= 1'b1;
      send_random(400);
      calm <= 1'b0;

      write_seed(32'h8000_0000);
      send_random(300);

      write_seed($urandom);
      send_random(770);

      req_tvalid <= 1'b0;
      while (draws.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (draws.errors == 0 && draws.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
